@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition must hold in every cycle out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

@@ design/utc_pkg.sv @@
// ----------------------------------------------------------------------------
// utc_pkg
// Constants, types and helper functions for the timestamp to calendar block.
// ----------------------------------------------------------------------------
package utc_pkg;

	localparam logic [31:0] EPOCH_2000    = 32'd946684800;
	localparam logic [8:0]  DAYS_COMMON   = 9'd365;
	localparam logic [15:0] DAYS_QUAD     = 16'd1461;
	localparam logic [3:0]  LAST_MONTH    = 4'd12;

	typedef enum logic [1:0] {
		PH_SEC,
		PH_MIN,
		PH_HOUR,
		PH_WDAY
	} div_phase_t;

	typedef struct packed {
		logic       load;
		logic       div_step;
		logic       div_end;
		div_phase_t phase;
		logic       quad_step;
		logic       year_step;
		logic       month_step;
		logic       publish;
	} utc_cmd_t;

	typedef struct packed {
		logic before_epoch;
		logic quad_ge;
		logic year_ge;
		logic month_ge;
		logic out_free;
	} utc_sts_t;

	function automatic logic [5:0] divisor(input div_phase_t ph);
		logic [5:0] d;
		unique case (ph) inside
			PH_SEC, PH_MIN: d = 6'd60;
			PH_HOUR:        d = 6'd24;
			PH_WDAY:        d = 6'd7;
			default:        d = 6'd60;
		endcase
		return d;
	endfunction

	// reciprocal of the divisor; shift is 37, 37, 36 and 32 by phase
	function automatic logic [31:0] recip_mult(input div_phase_t ph);
		logic [31:0] m;
		unique case (ph) inside
			PH_SEC, PH_MIN: m = 32'h88888889;
			PH_HOUR:        m = 32'hAAAAAAAB;
			PH_WDAY:        m = 32'h24924925;
			default:        m = 32'h88888889;
		endcase
		return m;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon) inside
			4'd2:                       len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
			default:                    len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ design/utc_datapath.sv @@
// ----------------------------------------------------------------------------
// utc_datapath
// Shared reciprocal multiplier for the constant divisions, year and month
// peeling, output register.
// ----------------------------------------------------------------------------
module utc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  utc_pkg::utc_cmd_t cmd,
	output utc_pkg::utc_sts_t sts,
	input  logic [31:0]       unix_seconds,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [6:0]        year_offset,
	output logic [3:0]        month,
	output logic [4:0]        day_of_month,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second,
	output logic [2:0]        weekday,
	output logic              before_epoch
);
	import utc_pkg::*;

	logic [31:0] dvd_q;
	logic [63:0] prod_q;
	logic        before_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hr_q;
	logic [2:0]  wday_q;
	logic [15:0] days_q;
	logic [6:0]  year_q;
	logic [3:0]  month_q;

	logic [6:0]  yr_out_q;
	logic [3:0]  mon_out_q;
	logic [4:0]  day_out_q;
	logic [4:0]  hr_out_q;
	logic [5:0]  min_out_q;
	logic [5:0]  sec_out_q;
	logic [2:0]  wday_out_q;
	logic        before_out_q;
	logic        out_valid_q;

	logic [31:0] mult;
	logic [5:0]  dsr;
	logic [31:0] quot;
	logic [11:0] qd;
	logic [5:0]  rmd;
	logic        leap;
	logic [8:0]  year_len;
	logic [4:0]  mon_len;

	// quotient from the registered product, remainder below 64 so six bits do
	always_comb begin
		mult = recip_mult(cmd.phase);
		dsr  = divisor(cmd.phase);
		unique case (cmd.phase) inside
			PH_SEC, PH_MIN: quot = {5'd0, prod_q[63:37]};
			PH_HOUR:        quot = {4'd0, prod_q[63:36]};
			PH_WDAY:        quot = prod_q[63:32];
			default:        quot = prod_q[63:32];
		endcase
		qd  = {6'd0, quot[5:0]} * {6'd0, dsr};
		rmd = dvd_q[5:0] - qd[5:0];
	end

	assign leap     = (year_q[1:0] == 2'b00);
	assign year_len = DAYS_COMMON + {8'd0, leap};
	assign mon_len  = month_len(month_q, leap);

	assign sts.before_epoch = before_q;
	assign sts.quad_ge      = (days_q >= DAYS_QUAD);
	assign sts.year_ge      = (days_q >= {7'd0, year_len});
	assign sts.month_ge     = (month_q < LAST_MONTH) && (days_q >= {11'd0, mon_len});
	assign sts.out_free     = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			before_q <= (unix_seconds < EPOCH_2000);
			dvd_q    <= unix_seconds - EPOCH_2000;
			year_q   <= '0;
			month_q  <= 4'd1;
		end
		if (cmd.div_step) begin
			prod_q <= {32'd0, dvd_q} * {32'd0, mult};
		end
		if (cmd.div_end) begin
			dvd_q <= quot;
			unique case (cmd.phase)
				PH_SEC:  sec_q <= rmd;
				PH_MIN:  min_q <= rmd;
				PH_HOUR: begin
					hr_q   <= rmd[4:0];
					days_q <= quot[15:0];
				end
				PH_WDAY: wday_q <= (rmd == 6'd0) ? 3'd6 : rmd[2:0] - 3'd1;
				default: ;
			endcase
		end
		if (cmd.quad_step) begin
			days_q <= days_q - DAYS_QUAD;
			year_q <= year_q + 7'd4;
		end
		if (cmd.year_step) begin
			days_q <= days_q - {7'd0, year_len};
			year_q <= year_q + 7'd1;
		end
		if (cmd.month_step) begin
			days_q  <= days_q - {11'd0, mon_len};
			month_q <= month_q + 4'd1;
		end
		if (cmd.publish) begin
			before_out_q <= before_q;
			if (before_q) begin
				yr_out_q   <= '0;
				mon_out_q  <= '0;
				day_out_q  <= '0;
				hr_out_q   <= '0;
				min_out_q  <= '0;
				sec_out_q  <= '0;
				wday_out_q <= '0;
			end else begin
				yr_out_q   <= year_q;
				mon_out_q  <= month_q;
				day_out_q  <= days_q[4:0] + 5'd1;
				hr_out_q   <= hr_q;
				min_out_q  <= min_q;
				sec_out_q  <= sec_q;
				wday_out_q <= wday_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign year_offset  = yr_out_q;
	assign month        = mon_out_q;
	assign day_of_month = day_out_q;
	assign hour         = hr_out_q;
	assign minute       = min_out_q;
	assign second       = sec_out_q;
	assign weekday      = wday_out_q;
	assign before_epoch = before_out_q;

endmodule

@@ design/utc_ctrl.sv @@
// ----------------------------------------------------------------------------
// utc_ctrl
// Sequencer: divider passes, year and month loops, hand-off to output stage.
// ----------------------------------------------------------------------------
module utc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  utc_pkg::utc_sts_t sts,
	output utc_pkg::utc_cmd_t cmd
);
	import utc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DIV_END,
		ST_QUAD,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	state_t     state_q;
	div_phase_t phase_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.phase      = phase_q;
		cmd.load       = in_valid && (state_q == ST_IDLE);
		cmd.div_step   = (state_q == ST_DIV);
		cmd.div_end    = (state_q == ST_DIV_END);
		cmd.quad_step  = (state_q == ST_QUAD) && sts.quad_ge;
		cmd.year_step  = (state_q == ST_YEAR) && sts.year_ge;
		cmd.month_step = (state_q == ST_MONTH) && sts.month_ge;
		cmd.publish    = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SEC;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					phase_q <= PH_SEC;
					state_q <= sts.before_epoch ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_DIV_END;
				end
				ST_DIV_END: begin
					unique case (phase_q)
						PH_SEC:  begin phase_q <= PH_MIN;  state_q <= ST_DIV; end
						PH_MIN:  begin phase_q <= PH_HOUR; state_q <= ST_DIV; end
						PH_HOUR: begin phase_q <= PH_WDAY; state_q <= ST_DIV; end
						PH_WDAY: state_q <= ST_QUAD;
						default: state_q <= ST_QUAD;
					endcase
				end
				ST_QUAD: begin
					if (!sts.quad_ge) state_q <= ST_YEAR;
				end
				ST_YEAR: begin
					if (!sts.year_ge) state_q <= ST_MONTH;
				end
				ST_MONTH: begin
					if (!sts.month_ge) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/unix_time_to_calendar_top.sv @@
// ----------------------------------------------------------------------------
// unix_time_to_calendar_top
// Unix timestamp to calendar date and time of day, counted from 2000.
// ----------------------------------------------------------------------------
// Takes one word at a time: a 32-bit Unix timestamp is accepted only when the
// block is idle. Its result is built by four passes through one shared 32x32
// reciprocal multiplier (divide by 60, 60, 24, then 7 for the weekday),
// followed by the subtraction loops that peel off four-year blocks (up to 26),
// single years (up to 3) and months (up to 11); no date needs more than 39
// steps in all. A timestamp before 2000 skips the divider and the loops.
// Every fourth year counts as leap, so dates are Gregorian through 2099. A
// finished word waits in the output register while the next conversion runs;
// the next word is published only once that register is free.
// ----------------------------------------------------------------------------
module unix_time_to_calendar_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] unix_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  year_offset,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [2:0]  weekday,
	output logic        before_epoch
);
	import utc_pkg::*;

	utc_cmd_t cmd;
	utc_sts_t sts;

	logic       in_acc;
	logic       out_pre;
	logic       out_cal;
	logic       pre_zero;
	logic       fields_ok;
	logic [6:0] cmd_bits;

	utc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	utc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.unix_seconds (unix_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year_offset  (year_offset),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.weekday      (weekday),
		.before_epoch (before_epoch)
	);

	assign in_acc    = in_valid && in_ready;
	assign out_pre   = out_valid && before_epoch;
	assign out_cal   = out_valid && !before_epoch;
	assign pre_zero  = (year_offset == 7'd0) && (month == 4'd0) && (day_of_month == 5'd0)
		&& (hour == 5'd0) && (minute == 6'd0) && (second == 6'd0) && (weekday == 3'd0);
	assign fields_ok = (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0)
		&& (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60) && (weekday < 3'd7);
	assign cmd_bits  = {cmd.load, cmd.div_step, cmd.div_end, cmd.quad_step, cmd.year_step,
		cmd.month_step, cmd.publish};

`include "assert_macros.svh"

	`ASSERT_NEXT(a_busy_after_load, clk, arst_n, in_acc, !in_ready, "no busy after accept")
	`ASSERT_IMPL(a_pre_epoch_zero, clk, arst_n, out_pre, pre_zero, "pre-2000 word not zero")
	`ASSERT_IMPL(a_fields_range, clk, arst_n, out_cal, fields_ok, "field out of range")
	`ASSERT_ALWAYS(a_cmd_onehot, clk, arst_n, $onehot0(cmd_bits), "conflicting commands")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Unix timestamp to calendar converter.
// ----------------------------------------------------------------------------
// Pushes timestamps through the valid/ready input channel. It starts with
// corner cases: the 2000 boundary, leap days, the turn of 2100 and the
// extremes of the 32-bit range. Random words follow, most of them placed on
// day, month and year edges. A scoreboard predicts every calendar word and
// checks each one on the output channel, field by field. Both channels idle
// at random, apart from one long stretch with no idling.
// ----------------------------------------------------------------------------

typedef struct {
	logic [6:0] year_offset;
	logic [3:0] month;
	logic [4:0] day_of_month;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;
	logic [2:0] weekday;
	logic       before_epoch;
} calendar_t;

class calendar_scoreboard;
	localparam int unsigned EPOCH_2000 = 32'd946684800;

	calendar_t   pending[$];
	int unsigned errors;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned pre_2000;
	int unsigned post_2099;

	function calendar_t predict_calendar(logic [31:0] ts);
		calendar_t   r;
		int unsigned rem;
		int unsigned total;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		int unsigned leap;
		int unsigned len;
		int unsigned mdays [11];
		mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30};
		r = '{default: '0};
		if (ts < EPOCH_2000) begin
			r.before_epoch = 1'b1;
			return r;
		end
		rem = ts - EPOCH_2000;
		r.second = 6'(rem % 60);
		rem = rem / 60;
		r.minute = 6'(rem % 60);
		rem = rem / 60;
		r.hour = 5'(rem % 24);
		total = rem / 24;
		days = total;
		yr = 0;
		leap = 1;
		while (days >= 365 + leap) begin
			days -= 365 + leap;
			yr++;
			leap = (yr % 4 == 0) ? 1 : 0;
		end
		for (mon = 1; mon < 12; mon++) begin
			len = mdays[mon - 1];
			if (leap != 0 && mon == 2)
				len++;
			if (days < len)
				break;
			days -= len;
		end
		r.year_offset  = 7'(yr);
		r.month        = 4'(mon);
		r.day_of_month = 5'(days + 1);
		r.weekday      = 3'((total + 6) % 7);
		return r;
	endfunction

	function void note_word(logic [31:0] ts);
		calendar_t c;
		c = predict_calendar(ts);
		pending.push_back(c);
		words_in++;
		if (c.before_epoch)
			pre_2000++;
		else if (c.year_offset >= 100)
			post_2099++;
	endfunction

	function void cmp_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_word(calendar_t got);
		calendar_t want;
		words_out++;
		if (pending.size() == 0) begin
			$error("calendar word with nothing outstanding");
			errors++;
			return;
		end
		want = pending.pop_front();
		cmp_field("year_offset", want.year_offset, got.year_offset);
		cmp_field("month", want.month, got.month);
		cmp_field("day_of_month", want.day_of_month, got.day_of_month);
		cmp_field("hour", want.hour, got.hour);
		cmp_field("minute", want.minute, got.minute);
		cmp_field("second", want.second, got.second);
		cmp_field("weekday", want.weekday, got.weekday);
		cmp_field("before_epoch", want.before_epoch, got.before_epoch);
	endfunction
endclass

module tb;
	localparam int unsigned EPOCH_2000   = 32'd946684800;
	localparam int unsigned RANDOM_WORDS = 1450;
	localparam int unsigned CALM_FIRST   = 500;
	localparam int unsigned CALM_LAST    = 800;
	localparam int unsigned DRAIN_CYCLES = 130;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned N_CORNERS    = 22;
	localparam logic [31:0] CORNER_WORDS [N_CORNERS] = '{
		32'd0, 32'd1, 32'd946684799, 32'd946684800, 32'd946684801,
		32'd951782399, 32'd951782400, 32'd951868800, 32'd978307199, 32'd978307200,
		32'd1078012800, 32'd1709164800, 32'd2147483647, 32'd2147483648,
		32'd4102444799, 32'd4102444800, 32'd4107542400, 32'd4107628800,
		32'd4294967294, 32'd4294967295, 32'hAAAAAAAA, 32'h55555555
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] unix_seconds = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  year_offset;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [2:0]  weekday;
	logic        before_epoch;

	bit                 calm = 1'b0;
	int unsigned        cycles = 0;
	calendar_scoreboard sb;

	unix_time_to_calendar_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.unix_seconds (unix_seconds),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.year_offset  (year_offset),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.weekday      (weekday),
		.before_epoch (before_epoch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// timestamps biased onto day, month and year edges
	function automatic logic [31:0] pick_timestamp();
		int unsigned     sel;
		int unsigned     yr;
		int unsigned     mon;
		int unsigned     len;
		int unsigned     dom;
		int unsigned     secs;
		int unsigned     i;
		longint unsigned day_no;
		longint unsigned t;
		int unsigned     mdays [12];
		mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		sel = $urandom_range(99);
		if (sel < 15)
			return $urandom();
		if (sel < 25)
			return $urandom_range(EPOCH_2000 - 1, 0);
		yr = $urandom_range(106);
		mon = $urandom_range(11);
		day_no = 365 * yr + (yr + 3) / 4;
		for (i = 0; i < mon; i++)
			day_no += mdays[i] + ((i == 1 && yr % 4 == 0) ? 1 : 0);
		len = mdays[mon] + ((mon == 1 && yr % 4 == 0) ? 1 : 0);
		case ($urandom_range(2))
			0: dom = 0;
			1: dom = len - 1;
			default: dom = $urandom_range(len - 1);
		endcase
		case ($urandom_range(3))
			0: secs = 0;
			1: secs = 86399;
			2: secs = $urandom_range(3);
			default: secs = $urandom_range(86399);
		endcase
		t = EPOCH_2000 + (day_no + dom) * 86400 + secs;
		if (secs == 0 && $urandom_range(1) == 1)
			t = t - 1 - $urandom_range(2);
		if (t > 64'hFFFFFFFF)
			t = 64'hFFFFFFFF - $urandom_range(100000);
		return t[31:0];
	endfunction

	task automatic send_word(input logic [31:0] ts);
		while (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		unix_seconds <= ts;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_word(ts);
	endtask

	// output side: check on handshake, then pick next ready
	initial begin
		calendar_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.year_offset  = year_offset;
				got.month        = month;
				got.day_of_month = day_of_month;
				got.hour         = hour;
				got.minute       = minute;
				got.second       = second;
				got.weekday      = weekday;
				got.before_epoch = before_epoch;
				sb.check_word(got);
			end
			out_ready <= calm || ($urandom_range(99) >= 21);
		end
	end

	initial begin
		int unsigned n;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (n = 0; n < N_CORNERS; n++)
			send_word(CORNER_WORDS[n]);
		for (n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n >= CALM_FIRST && n < CALM_LAST);
			send_word(pick_timestamp());
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d calendar words never arrived", sb.pending.size());
			sb.errors++;
		end

		$display("Converted %0d timestamps: %0d before 2000, %0d in 2100 or later.",
			sb.words_in, sb.pre_2000, sb.post_2099);
		$display("Checked %0d calendar words, %0d field mismatches.",
			sb.words_out, sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
